// ===== design/bpl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bounded positional list unit.
// No dependencies; used by bpl_cell and bounded_positional_list_unit.
package bpl_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ELEM_WIDTH    = 32;
   localparam int POS_WIDTH     = 5;
   localparam int CAP_WIDTH     = 5;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_READ   = 2'd2;
   localparam func_type FUNC_CLEAR  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_FULL   = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   // Per-cell command: where a cell takes its next value from.
   typedef logic [1:0] cell_cmd_type;
   localparam cell_cmd_type CELL_HOLD       = 2'd0;
   localparam cell_cmd_type CELL_TAKE_LOWER = 2'd1;
   localparam cell_cmd_type CELL_TAKE_UPPER = 2'd2;
   localparam cell_cmd_type CELL_LOAD       = 2'd3;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

endpackage

// ===== design/bpl_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one element handle.
// Depends on bpl_pkg for the command codes and element type.
module bpl_cell (
   input  logic                  clock,
   input  bpl_pkg::cell_cmd_type cmd,
   input  bpl_pkg::elem_type     lower_data,
   input  bpl_pkg::elem_type     upper_data,
   input  bpl_pkg::elem_type     load_data,
   output bpl_pkg::elem_type     data
);

   bpl_pkg::elem_type data_ff;
   bpl_pkg::elem_type data_in;

   always_comb begin
      case (cmd)
         bpl_pkg::CELL_TAKE_LOWER: data_in = lower_data;
         bpl_pkg::CELL_TAKE_UPPER: data_in = upper_data;
         bpl_pkg::CELL_LOAD:       data_in = load_data;
         default:                  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/bounded_positional_list_unit.sv =====
`timescale 1ns / 1ps
// Bounded positional list: insert, remove, read at a position, or clear.
// The response word is registered and appears in the cycle after its request is taken.
// One word per cycle unless rsp_stall holds the response; the register frees as it drains.
// Reset (synchronous, active high): count zero, capacity 16, no response pending.
// Cell contents are not reset; only cells below the count are ever read.
// Depends on bpl_pkg and bpl_cell.
module bounded_positional_list_unit #(
   parameter int DEPTH = bpl_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [bpl_pkg::CAP_WIDTH-1:0]     csr_wr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bpl_pkg::func_type                 req_func,
   input  logic [bpl_pkg::POS_WIDTH-1:0]     req_position,
   input  bpl_pkg::elem_type                 req_element,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bpl_pkg::status_type               rsp_status,
   output bpl_pkg::elem_type                 rsp_read_element,
   output logic [bpl_pkg::POS_WIDTH-1:0]     rsp_count,
   output logic                              rsp_is_full,
   output logic                              rsp_is_empty
);

   // Count needs to reach DEPTH itself; compares run at the wider of that and the port width.
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > bpl_pkg::POS_WIDTH) ? CW : bpl_pkg::POS_WIDTH;

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  count_in;
   logic [bpl_pkg::CAP_WIDTH-1:0]  capacity_ff;

   logic                           rsp_valid_ff;
   bpl_pkg::status_type            rsp_status_ff;
   bpl_pkg::status_type            rsp_status_in;
   bpl_pkg::elem_type              rsp_elem_ff;
   bpl_pkg::elem_type              rsp_elem_in;
   logic [bpl_pkg::POS_WIDTH-1:0]  rsp_count_ff;
   logic                           rsp_full_ff;
   logic                           rsp_full_in;
   logic                           rsp_empty_ff;
   logic                           rsp_empty_in;

   // ---------------------------------------------------------------
   // Handshake: hold the request only while a response sits unread.
   // ---------------------------------------------------------------
   logic req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Operation decode
   // ---------------------------------------------------------------
   logic [MW-1:0] pos_ext;
   logic [MW-1:0] cnt_ext;
   logic [MW-1:0] cap_ext;
   logic [MW-1:0] cap_eff;
   logic [MW-1:0] new_cnt;
   logic          ins_ok;
   logic          rem_ok;
   logic          rd_ok;

   assign pos_ext = MW'(req_position);
   assign cnt_ext = MW'(count_ff);
   assign cap_ext = MW'(capacity_ff);

   // Effective capacity: zero acts as one, anything above the built depth saturates.
   always_comb begin
      if (cap_ext == '0) begin
         cap_eff = MW'(1);
      end else if (cap_ext > MW'(DEPTH)) begin
         cap_eff = MW'(DEPTH);
      end else begin
         cap_eff = cap_ext;
      end
   end

   always_comb begin
      rsp_status_in = bpl_pkg::ST_OK;
      new_cnt       = cnt_ext;
      ins_ok        = 1'b0;
      rem_ok        = 1'b0;
      rd_ok         = 1'b0;
      case (req_func)
         bpl_pkg::FUNC_INSERT: begin
            // Position check comes before the full check; position == count appends.
            if (pos_ext > cnt_ext) begin
               rsp_status_in = bpl_pkg::ST_BADPOS;
            end else if (cnt_ext >= cap_eff) begin
               rsp_status_in = bpl_pkg::ST_FULL;
            end else begin
               ins_ok  = 1'b1;
               new_cnt = cnt_ext + MW'(1);
            end
         end
         bpl_pkg::FUNC_REMOVE: begin
            if (cnt_ext == '0) begin
               rsp_status_in = bpl_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               rsp_status_in = bpl_pkg::ST_BADPOS;
            end else begin
               rem_ok  = 1'b1;
               new_cnt = cnt_ext - MW'(1);
            end
         end
         bpl_pkg::FUNC_READ: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = bpl_pkg::ST_BADPOS;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
            // clear always succeeds
            new_cnt = '0;
         end
      endcase
   end

   assign count_in     = new_cnt[CW-1:0];
   assign rsp_full_in  = (new_cnt >= cap_eff);
   assign rsp_empty_in = (new_cnt == '0);

   // ---------------------------------------------------------------
   // Cell chain: each cell picks its own next value from its neighbors.
   // Insert moves cells above the position up one; remove pulls cells at
   // and above the position down one, with zero entering at the top.
   // ---------------------------------------------------------------
   bpl_pkg::elem_type    cell_data [DEPTH];
   bpl_pkg::cell_cmd_type cell_cmd [DEPTH];
   logic [DEPTH-1:0]     cell_hit;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bpl_pkg::elem_type lower_data;
      bpl_pkg::elem_type upper_data;

      if (i == 0) begin : g_bottom
         assign lower_data = '0;
      end else begin : g_lower
         assign lower_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign upper_data = '0;
      end else begin : g_upper
         assign upper_data = cell_data[i+1];
      end

      assign cell_hit[i] = (pos_ext == MW'(i));

      always_comb begin
         cell_cmd[i] = bpl_pkg::CELL_HOLD;
         if (req_take && ins_ok) begin
            if (MW'(i) > pos_ext) begin
               cell_cmd[i] = bpl_pkg::CELL_TAKE_LOWER;
            end else if (cell_hit[i]) begin
               cell_cmd[i] = bpl_pkg::CELL_LOAD;
            end
         end else if (req_take && rem_ok) begin
            if (MW'(i) >= pos_ext) begin
               cell_cmd[i] = bpl_pkg::CELL_TAKE_UPPER;
            end
         end
      end

      bpl_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd[i]),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .load_data  (req_element),
         .data       (cell_data[i])
      );
   end

   // Read: AND-OR select of the cell at the position; zero when not a valid read.
   always_comb begin
      rsp_elem_in = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rsp_elem_in = rsp_elem_in | (cell_data[k] & {bpl_pkg::ELEM_WIDTH{cell_hit[k] && rd_ok}});
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= bpl_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (req_take) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            // drop the response once taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload: advance only with an accepted request.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_status_ff <= rsp_status_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_count_ff  <= new_cnt[bpl_pkg::POS_WIDTH-1:0];
         rsp_full_ff   <= rsp_full_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_element = rsp_elem_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_is_full      = rsp_full_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bounded_positional_list_unit: directed and random list
// operations are mirrored in a shadow list and every response word is checked.
// Depends on bpl_pkg and the list unit RTL; reads no files.
module testbench;
   import bpl_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1650;
   localparam int PHASE_ITEMS  = 110;
   localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
   localparam int LONG_HOLD    = 80;     // receiver hold-off, in cycles

   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef logic [CAP_WIDTH-1:0] cap_type;

   // One response word, field by field.
   typedef struct {
      status_type status;
      elem_type   element;
      pos_type    count;
      logic       is_full;
      logic       is_empty;
   } list_reply_type;

   // Shadow copy of the list: predicts each response word at request
   // acceptance and holds the predictions until the responses arrive.
   class list_mirror;
      elem_type       cells[LIST_DEPTH];
      int unsigned    held;
      cap_type        capacity;
      list_reply_type awaited[$];
      int unsigned    mismatches;
      int unsigned    status_seen[4];
      int unsigned    func_seen[4];

      function new();
         held       = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
         foreach (cells[i]) cells[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         foreach (func_seen[i]) func_seen[i] = 0;
      endfunction

      function void set_capacity(cap_type value);
         capacity = value;
      endfunction

      // Zero acts as one; anything above the built depth saturates.
      function int unsigned room();
         if (capacity == 0) return 1;
         if (capacity > LIST_DEPTH) return LIST_DEPTH;
         return capacity;
      endfunction

      function void note_request(func_type op, pos_type pos, elem_type elem);
         list_reply_type reply;
         int unsigned lim;
         lim          = room();
         reply.status  = ST_OK;
         reply.element = '0;
         case (op)
            FUNC_INSERT: begin
               // position check comes ahead of the full check
               if (pos > held) reply.status = ST_BADPOS;
               else if (held >= lim) reply.status = ST_FULL;
               else begin
                  for (int i = held; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = elem;
                  held++;
               end
            end
            FUNC_REMOVE: begin
               if (held == 0) reply.status = ST_EMPTY;
               else if (pos >= held) reply.status = ST_BADPOS;
               else begin
                  for (int i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
                  cells[held-1] = '0;
                  held--;
               end
            end
            FUNC_READ: begin
               if (pos >= held) reply.status = ST_BADPOS;
               else reply.element = cells[pos];
            end
            default: held = 0;
         endcase
         reply.count    = pos_type'(held);
         reply.is_full  = (held >= lim);
         reply.is_empty = (held == 0);
         func_seen[op]++;
         status_seen[reply.status]++;
         awaited.push_back(reply);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(list_reply_type got);
         list_reply_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response word with nothing awaited, expected none, actual status %0d",
                     $time, got.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare("status", 32'(want.status), 32'(got.status));
         compare("read_element", want.element, got.element);
         compare("count", 32'(want.count), 32'(got.count));
         compare("is_full", 32'(want.is_full), 32'(got.is_full));
         compare("is_empty", 32'(want.is_empty), 32'(got.is_empty));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   cap_type    csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   func_type   req_func;
   pos_type    req_position;
   elem_type   req_element;
   logic       rsp_valid;
   logic       rsp_stall;
   status_type rsp_status;
   elem_type   rsp_read_element;
   pos_type    rsp_count;
   logic       rsp_is_full;
   logic       rsp_is_empty;

   list_mirror  tracker;
   bit          sender_idles;
   bit          sink_idles;
   bit          long_hold_request;
   int unsigned quiet_cycles;
   int unsigned cap_writes;

   bounded_positional_list_unit #(.DEPTH(LIST_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_position     (req_position),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_element (rsp_read_element),
      .rsp_count        (rsp_count),
      .rsp_is_full      (rsp_is_full),
      .rsp_is_empty     (rsp_is_empty)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Response side: check each accepted word, then pick the stall for the
   // next cycle. A long hold-off asked for by the stimulus takes priority
   // over the short random bursts; its length is counted here.
   initial begin
      int unsigned    hold_left;
      int unsigned    burst_left;
      bit             stall_next;
      list_reply_type got;
      hold_left  = 0;
      burst_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status   = rsp_status;
            got.element  = rsp_read_element;
            got.count    = rsp_count;
            got.is_full  = rsp_is_full;
            got.is_empty = rsp_is_empty;
            tracker.check_response(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left  = LONG_HOLD - 1;
            stall_next = 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            stall_next = 1'b1;
         end else if (sink_idles && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 11) - 1;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Offer one request word and hold it until the block takes it, then
   // record it in the shadow list. Valid stays high on return so that
   // back-to-back words need no extra edge.
   task automatic issue_request(input func_type op, input pos_type pos, input elem_type elem);
      req_valid    <= 1'b1;
      req_func     <= op;
      req_position <= pos;
      req_element  <= elem;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, pos, elem);
   endtask

   // Drop valid for a burst of idle cycles.
   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response word has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register; only called with the block drained.
   task automatic write_capacity(input cap_type value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_capacity(value);
      cap_writes++;
   endtask

   // Operation mix leans toward growth or shrinkage so the count sweeps
   // between empty and full; clear stays rare.
   function automatic func_type pick_func(bit growing);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return FUNC_CLEAR;
      if (roll < (growing ? 57 : 27)) return FUNC_INSERT;
      if (roll < 77) return FUNC_REMOVE;
      return FUNC_READ;
   endfunction

   // Mostly positions that are legal for the current count, with some
   // noise across the whole field.
   function automatic pos_type pick_position(func_type op);
      int unsigned n;
      n = tracker.held;
      if (op == FUNC_CLEAR || $urandom_range(0, 99) < 12) return pos_type'($urandom_range(0, 31));
      if (op == FUNC_INSERT) return pos_type'($urandom_range(0, n));
      if (n == 0) return pos_type'($urandom_range(0, 31));
      return pos_type'($urandom_range(0, n - 1));
   endfunction

   initial begin
      int unsigned issued;
      int unsigned phase;
      cap_type     cap;
      bit          growing;
      bit          quiet;
      func_type    op;
      tracker           = new();
      sender_idles      = 1'b0;
      sink_idles        = 1'b0;
      long_hold_request = 1'b0;
      quiet_cycles      = 0;
      cap_writes        = 0;
      issued            = 0;
      growing           = 1'b1;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_valid    <= 1'b0;
      req_func     <= FUNC_READ;
      req_position <= '0;
      req_element  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list corners at the reset capacity.
      issue_request(FUNC_READ,   5'd0,  32'h1234_5678);
      issue_request(FUNC_REMOVE, 5'd0,  '0);
      issue_request(FUNC_REMOVE, 5'd31, '0);
      issue_request(FUNC_INSERT, 5'd1,  32'hDEAD_BEEF);
      // Build a short list: first, front, append and middle inserts.
      issue_request(FUNC_INSERT, 5'd0,  32'hFFFF_FFFF);
      issue_request(FUNC_INSERT, 5'd0,  32'h0000_0000);
      issue_request(FUNC_INSERT, 5'd2,  32'hA5A5_A5A5);
      issue_request(FUNC_INSERT, 5'd1,  32'h5A5A_5A5A);
      issue_request(FUNC_READ,   5'd3,  '0);
      issue_request(FUNC_READ,   5'd4,  '0);
      issue_request(FUNC_READ,   5'd31, '0);
      issue_request(FUNC_REMOVE, 5'd1,  '0);
      issue_request(FUNC_REMOVE, 5'd4,  '0);
      issue_request(FUNC_CLEAR,  5'd17, '0);
      issue_request(FUNC_READ,   5'd0,  '0);
      // Capacity zero behaves as one; a bad position beats the full check.
      write_capacity(5'd0);
      issue_request(FUNC_INSERT, 5'd0,  32'h0000_0001);
      issue_request(FUNC_INSERT, 5'd0,  32'h8000_0000);
      issue_request(FUNC_INSERT, 5'd5,  32'h7FFF_FFFF);
      // Above the depth saturates; then lower the limit under the count.
      write_capacity(5'd31);
      issue_request(FUNC_INSERT, 5'd1,  32'h0F0F_0F0F);
      issue_request(FUNC_INSERT, 5'd0,  32'hF0F0_F0F0);
      issue_request(FUNC_INSERT, 5'd3,  32'h3C3C_3C3C);
      write_capacity(5'd2);
      issue_request(FUNC_INSERT, 5'd0,  32'hCAFE_F00D);
      issue_request(FUNC_REMOVE, 5'd0,  '0);
      issue_request(FUNC_CLEAR,  5'd0,  '0);

      // Random phases, each under its own capacity. The first few hit the
      // extremes; the count carries over so a lowered limit finds it high.
      for (phase = 0; issued < RANDOM_ITEMS; phase++) begin
         case (phase)
            0:       cap = 5'd16;
            1:       cap = 5'd31;
            2:       cap = 5'd1;
            3:       cap = 5'd0;
            4:       cap = 5'd2;
            default: cap = cap_type'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         // no idling on either side in the closing phases
         quiet        = (issued + 2 * PHASE_ITEMS >= RANDOM_ITEMS);
         sender_idles = !quiet && $urandom_range(0, 2) != 0;
         sink_idles   = !quiet && $urandom_range(0, 2) != 0;
         if (phase == 6) begin
            // hold the receiver off while the sender keeps offering words
            sender_idles      = 1'b0;
            long_hold_request = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 30 == 0) growing = $urandom_range(0, 1);
            op = pick_func(growing);
            issue_request(op, pick_position(op), elem_type'($urandom()));
            issued++;
            if (sender_idles && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 11));
         end
      end

      // Wait out the last responses, then give any stray word time to show up.
      drain_responses();
      repeat (3) @(posedge clock);

      $display("Ran %0d words (%0d insert, %0d remove, %0d read, %0d clear), %0d cap writes.",
               tracker.func_seen[FUNC_INSERT] + tracker.func_seen[FUNC_REMOVE]
               + tracker.func_seen[FUNC_READ] + tracker.func_seen[FUNC_CLEAR],
               tracker.func_seen[FUNC_INSERT], tracker.func_seen[FUNC_REMOVE],
               tracker.func_seen[FUNC_READ], tracker.func_seen[FUNC_CLEAR], cap_writes);
      $display("Statuses: %0d ok, %0d bad position, %0d full, %0d empty; %0d mismatches.",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_BADPOS],
               tracker.status_seen[ST_FULL], tracker.status_seen[ST_EMPTY], tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
